FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL, included by the receive window top.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside of reset.
`define SRRW_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("srrw check failed");

// Check that a condition holds in the cycle after a trigger.
`define SRRW_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("srrw sequence check failed");

`endif

FILE: rtl/srrw_pkg.sv
package srrw_pkg;

  // Field widths of the packet descriptor and the results
  localparam int SEQ_W    = 8;
  localparam int LEN_W    = 10;
  localparam int HANDLE_W = 16;
  localparam int WIN_W    = 7;

  // Reset value of the end-of-transfer length threshold
  localparam logic [LEN_W-1:0] FULL_LEN_RST = 10'd512;

  // Result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_READ = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_ACK  = 5'b10000
  } state_t;

endpackage

FILE: rtl/selective_repeat_receive_window_top.sv
// Channel   Direction  Transaction when            Carries
// in_       input      start & !busy at clk edge    seq number, check flag, length, handle
// out_      output     out_valid at clk edge        deliver or acknowledgement result
// cfg_      input      cfg_valid & cfg_ready        end-of-transfer length threshold
//
// A packet passes EVAL, READ, one EMIT per slot released in order (0 to WINDOW_SLOTS)
// then ACK; a dropped packet returns from EVAL to idle. The payload store has one read
// port, so release runs at one slot per cycle, the first read being issued in READ.
// Reset is synchronous and active low; slot-held bits are flip-flops cleared at once,
// so no clearing pass is needed. Results cannot be stalled; start is ignored while busy.
module selective_repeat_receive_window_top #(
  parameter int WINDOW_SLOTS = 31,
  parameter int SEQ_SPACE    = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // packet descriptor
  input  logic                          start,
  output logic                          busy,
  input  logic [srrw_pkg::SEQ_W-1:0]    in_seq_number,
  input  logic                          in_check_ok,
  input  logic [srrw_pkg::LEN_W-1:0]    in_payload_length,
  input  logic [srrw_pkg::HANDLE_W-1:0] in_payload_handle,
  // results
  output logic                          out_valid,
  output logic                          out_result_kind,
  output logic [srrw_pkg::HANDLE_W-1:0] out_delivered_handle,
  output logic [srrw_pkg::LEN_W-1:0]    out_delivered_length,
  output logic [srrw_pkg::SEQ_W-1:0]    out_ack_next_seq,
  output logic [srrw_pkg::WIN_W-1:0]    out_ack_window,
  output logic                          out_transfer_done,
  output logic                          out_last_of_run,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srrw_pkg::LEN_W-1:0]    cfg_full_payload_length
);
  import srrw_pkg::*;

  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int PEND_W = $clog2(WINDOW_SLOTS + 1);
  localparam int DATA_W = HANDLE_W + LEN_W;

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      full_len_r;
  logic [SEQ_W-1:0]      seq_r;
  logic                  ok_r;
  logic [LEN_W-1:0]      len_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [WINDOW_SLOTS-1:0] valid_r, valid_nxt;
  logic [SEQ_W-1:0]      lio_r, lio_nxt, lio_inc;
  logic [SLOT_W-1:0]     head_r, head_nxt, head_inc;
  logic [PEND_W-1:0]     pend_r, pend_nxt;
  logic                  end_r, end_nxt;
  logic [DATA_W-1:0]     slot_mem [WINDOW_SLOTS];
  logic [DATA_W-1:0]     rd_data_r;
  logic                  mem_we, mem_re;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SEQ_W-1:0]      seq_mod_tbl [256];
  logic [SEQ_W:0]        dist_sum;
  logic [SEQ_W-1:0]      seq_dist;
  logic                  in_win;
  logic [SEQ_W:0]        slot_sum;
  logic [SLOT_W-1:0]     slot;
  logic                  accept;
  logic                  emit_st, ack_st;

  // Reduce a sequence number into the sequence space
  for (genvar g = 0; g < 256; g++) begin : g_seq_mod
    assign seq_mod_tbl[g] = SEQ_W'(g % SEQ_SPACE);
  end

  assign accept    = start & ~busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_len_r <= FULL_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      full_len_r <= cfg_full_payload_length;
    end
  end

  // Capture the descriptor on a start transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r    <= seq_mod_tbl[in_seq_number];
      ok_r     <= in_check_ok;
      len_r    <= in_payload_length;
      handle_r <= in_payload_handle;
    end
  end

  // Distance from the last in-order number, and the slot it maps to
  always_comb begin
    dist_sum = {1'b0, seq_r} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, lio_r};
    seq_dist = (dist_sum >= (SEQ_W+1)'(SEQ_SPACE)) ?
               SEQ_W'(dist_sum - (SEQ_W+1)'(SEQ_SPACE)) : dist_sum[SEQ_W-1:0];
    in_win   = (seq_dist != '0) && (seq_dist <= SEQ_W'(WINDOW_SLOTS));
    slot_sum = (SEQ_W+1)'(head_r) + {1'b0, seq_dist} - (SEQ_W+1)'(1);
    slot     = (slot_sum >= (SEQ_W+1)'(WINDOW_SLOTS)) ?
               SLOT_W'(slot_sum - (SEQ_W+1)'(WINDOW_SLOTS)) : SLOT_W'(slot_sum);
  end

  // Advance head and last in-order number with wrap
  assign head_inc = (head_r == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : head_r + SLOT_W'(1);
  assign lio_inc  = (lio_r == SEQ_W'(SEQ_SPACE - 1)) ? '0 : lio_r + SEQ_W'(1);

  // Sequence store, release and acknowledgement
  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    head_nxt  = head_r;
    lio_nxt   = lio_r;
    pend_nxt  = pend_r;
    end_nxt   = end_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rd_addr   = head_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (ok_r && in_win) begin
          mem_we          = 1'b1;
          valid_nxt[slot] = 1'b1;
          if (!valid_r[slot]) pend_nxt = pend_r + PEND_W'(1);
          if (len_r < full_len_r) end_nxt = 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (valid_r[head_r]) begin
          mem_re    = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_EMIT: begin
        valid_nxt[head_r] = 1'b0;
        head_nxt          = head_inc;
        lio_nxt           = lio_inc;
        pend_nxt          = pend_r - PEND_W'(1);
        // Prefetch the next slot while this one goes out
        if ((head_inc != head_r) && valid_r[head_inc]) begin
          mem_re  = 1'b1;
          rd_addr = head_inc;
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      lio_r   <= SEQ_W'(SEQ_SPACE - 1);
      head_r  <= '0;
      pend_r  <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      lio_r   <= lio_nxt;
      head_r  <= head_nxt;
      pend_r  <= pend_nxt;
      end_r   <= end_nxt;
    end
  end

  // Payload store: write the slot, registered read
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[slot] <= {handle_r, len_r};
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= slot_mem[rd_addr];
  end

  // Drive results
  assign emit_st              = (state_r == ST_EMIT);
  assign ack_st               = (state_r == ST_ACK);
  assign out_valid            = emit_st | ack_st;
  assign out_result_kind      = ack_st ? KIND_ACK : KIND_DELIVER;
  assign out_delivered_handle = emit_st ? rd_data_r[DATA_W-1:LEN_W] : '0;
  assign out_delivered_length = emit_st ? rd_data_r[LEN_W-1:0] : '0;
  assign out_ack_next_seq     = ack_st ? lio_inc : '0;
  assign out_ack_window       = ack_st ? WIN_W'(WINDOW_SLOTS) : '0;
  assign out_transfer_done    = ack_st & end_r & (pend_r == '0);
  assign out_last_of_run      = ack_st;

`include "assert_macros.svh"

  `SRRW_ASSERT(a_pend_matches_held, $countones(valid_r) == int'(pend_r))
  `SRRW_ASSERT(a_emit_slot_held, !emit_st || valid_r[head_r])
  `SRRW_ASSERT_NEXT(a_ack_ends_run, ack_st, state_r == ST_IDLE)
  `SRRW_ASSERT_NEXT(a_accept_goes_busy, accept, busy && !out_valid)

endmodule

FILE: verif/tb.sv
module tb;
  import srrw_pkg::*;

  localparam int WINDOW      = 31;
  localparam int SEQ_SPACE   = 256;
  localparam int LATENCY     = 8;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic [SEQ_W-1:0]    next_seq;
    logic [WIN_W-1:0]    window;
    logic                done;
    logic                last;
  } window_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [SEQ_W-1:0]    in_seq_number = '0;
  logic                in_check_ok = 1'b0;
  logic [LEN_W-1:0]    in_payload_length = '0;
  logic [HANDLE_W-1:0] in_payload_handle = '0;
  logic                out_valid;
  logic                out_result_kind;
  logic [HANDLE_W-1:0] out_delivered_handle;
  logic [LEN_W-1:0]    out_delivered_length;
  logic [SEQ_W-1:0]    out_ack_next_seq;
  logic [WIN_W-1:0]    out_ack_window;
  logic                out_transfer_done;
  logic                out_last_of_run;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_full_payload_length = '0;

  // Receive window mirror
  logic [LEN_W-1:0]    end_threshold;
  logic                slot_held [WINDOW];
  logic [HANDLE_W-1:0] slot_hdl [WINDOW];
  logic [LEN_W-1:0]    slot_len [WINDOW];
  logic [SEQ_W-1:0]    last_delivered_seq;
  int unsigned         head_slot;
  int unsigned         held_count;
  logic                end_marked;

  window_result_t      outstanding_results [$];
  int                  error_count = 0;
  int                  stall_cycles = 0;
  logic                steady_sender = 1'b0;

  selective_repeat_receive_window_top #(
    .WINDOW_SLOTS(WINDOW),
    .SEQ_SPACE   (SEQ_SPACE)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_seq_number          (in_seq_number),
    .in_check_ok            (in_check_ok),
    .in_payload_length      (in_payload_length),
    .in_payload_handle      (in_payload_handle),
    .out_valid              (out_valid),
    .out_result_kind        (out_result_kind),
    .out_delivered_handle   (out_delivered_handle),
    .out_delivered_length   (out_delivered_length),
    .out_ack_next_seq       (out_ack_next_seq),
    .out_ack_window         (out_ack_window),
    .out_transfer_done      (out_transfer_done),
    .out_last_of_run        (out_last_of_run),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_full_payload_length(cfg_full_payload_length)
  );

  always #2 clk = ~clk;

  // Clear the window mirror to its reset state
  function automatic void clear_window();
    end_threshold      = FULL_LEN_RST;
    last_delivered_seq = SEQ_W'(SEQ_SPACE - 1);
    head_slot          = 0;
    held_count         = 0;
    end_marked         = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      slot_held[i] = 1'b0;
      slot_hdl[i]  = '0;
      slot_len[i]  = '0;
    end
  endfunction

  function automatic logic seq_in_window(input logic [SEQ_W-1:0] seq);
    logic [SEQ_W-1:0] seq_dist;
    seq_dist = seq - last_delivered_seq;
    return seq_dist != 0 && seq_dist <= WINDOW;
  endfunction

  // Store one good in-window packet, release the in-order run and queue the resulting transactions
  function automatic void advance_window(input logic [SEQ_W-1:0] seq, input logic ok,
                                         input logic [LEN_W-1:0] len,
                                         input logic [HANDLE_W-1:0] hdl);
    logic [SEQ_W-1:0] seq_dist;
    int unsigned      slot;
    window_result_t   res;
    seq_dist = seq - last_delivered_seq;
    if (!ok || seq_dist == 0 || seq_dist > WINDOW) return;
    slot = (head_slot + seq_dist - 1) % WINDOW;
    if (!slot_held[slot]) begin
      slot_held[slot] = 1'b1;
      held_count++;
    end
    slot_hdl[slot] = hdl;
    slot_len[slot] = len;
    if (len < end_threshold) end_marked = 1'b1;
    // release oldest first
    while (slot_held[head_slot]) begin
      res          = '0;
      res.kind     = KIND_DELIVER;
      res.handle   = slot_hdl[head_slot];
      res.length   = slot_len[head_slot];
      outstanding_results.push_back(res);
      slot_held[head_slot] = 1'b0;
      last_delivered_seq++;
      head_slot = (head_slot + 1) % WINDOW;
      if (held_count > 0) held_count--;
    end
    res          = '0;
    res.kind     = KIND_ACK;
    res.next_seq = last_delivered_seq + 1'b1;
    res.window   = WIN_W'(WINDOW);
    res.done     = end_marked && held_count == 0;
    res.last     = 1'b1;
    outstanding_results.push_back(res);
  endfunction

  // Compare each result transaction with the oldest expected one
  always @(posedge clk) begin
    window_result_t exp_res;
    if (rst_n && out_valid) begin
      if (outstanding_results.size() == 0) begin
        $error("unexpected result: kind %0d handle %0h", out_result_kind,
               out_delivered_handle);
        error_count++;
      end else begin
        exp_res = outstanding_results.pop_front();
        if (out_result_kind !== exp_res.kind) begin
          $error("out_result_kind: expected %0d, got %0d", exp_res.kind, out_result_kind);
          error_count++;
        end
        if (out_delivered_handle !== exp_res.handle) begin
          $error("out_delivered_handle: expected %0h, got %0h", exp_res.handle,
                 out_delivered_handle);
          error_count++;
        end
        if (out_delivered_length !== exp_res.length) begin
          $error("out_delivered_length: expected %0d, got %0d", exp_res.length,
                 out_delivered_length);
          error_count++;
        end
        if (out_ack_next_seq !== exp_res.next_seq) begin
          $error("out_ack_next_seq: expected %0d, got %0d", exp_res.next_seq,
                 out_ack_next_seq);
          error_count++;
        end
        if (out_ack_window !== exp_res.window) begin
          $error("out_ack_window: expected %0d, got %0d", exp_res.window, out_ack_window);
          error_count++;
        end
        if (out_transfer_done !== exp_res.done) begin
          $error("out_transfer_done: expected %0d, got %0d", exp_res.done,
                 out_transfer_done);
          error_count++;
        end
        if (out_last_of_run !== exp_res.last) begin
          $error("out_last_of_run: expected %0d, got %0d", exp_res.last, out_last_of_run);
          error_count++;
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one packet, idling at random first unless the sender is steady, and hold it until accepted
  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                             input logic [LEN_W-1:0] len, input logic [HANDLE_W-1:0] hdl);
    @(negedge clk);
    if (!steady_sender && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 35) @(negedge clk);
    end
    start             <= 1'b1;
    in_seq_number     <= seq;
    in_check_ok       <= ok;
    in_payload_length <= len;
    in_payload_handle <= hdl;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_window(seq, ok, len, hdl);
  endtask

  // Drop start and wait until every expected result has come
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [LEN_W-1:0] value);
    drain_results();
    // let a trailing dropped packet finish
    repeat (LATENCY) @(negedge clk);
    cfg_valid               <= 1'b1;
    cfg_full_payload_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    end_threshold = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-window packets, many near the head, some failed checks and strays
  task automatic send_random_packet(output logic counted);
    logic [SEQ_W-1:0] seq;
    logic             ok;
    int unsigned      pick;
    pick = $urandom_range(99);
    ok   = 1'b1;
    if (pick < 40) seq = last_delivered_seq + 8'd1 + SEQ_W'($urandom_range(3));
    else if (pick < 78) seq = last_delivered_seq + 8'd1 + SEQ_W'($urandom_range(WINDOW - 1));
    else if (pick < 88) begin
      seq = SEQ_W'($urandom_range(SEQ_SPACE - 1));
      ok  = 1'b0;
    end else seq = SEQ_W'($urandom_range(SEQ_SPACE - 1));
    counted = ok && seq_in_window(seq);
    send_packet(seq, ok, LEN_W'($urandom_range(512)), HANDLE_W'($urandom_range(65535)));
  endtask

  task automatic run_random_phase(input int target, input logic pause_midway);
    int   meaningful;
    logic counted;
    meaningful = 0;
    while (meaningful < target) begin
      send_random_packet(counted);
      if (counted) meaningful++;
      if (pause_midway && meaningful == target / 2) begin
        drain_results();
        pause_midway = 1'b0;
      end
    end
  endtask

  // In-order packets at the reset threshold, full length so no end mark
  task automatic test_reset_threshold();
    send_packet(8'd0, 1'b1, 10'd512, 16'h0000);
    send_packet(8'd1, 1'b1, 10'd512, 16'hFFFF);
    send_packet(8'd2, 1'b1, 10'd512, HANDLE_W'($urandom_range(65535)));
    send_packet(8'd3, 1'b1, 10'd512, 16'h5A5A);
  endtask

  // Threshold at one, packets reordered within the window
  task automatic test_reorder();
    logic [SEQ_W-1:0] base;
    write_threshold(10'd1);
    base = last_delivered_seq + 8'd1;
    send_packet(base + 8'd2, 1'b1, 10'd1, 16'h1234);
    send_packet(base + 8'd1, 1'b1, 10'd511, 16'hABCD);
    send_packet(base, 1'b1, 10'd512, 16'h0F0F);
  endtask

  // Failed checks, window edges and a duplicate of a buffered packet
  task automatic test_drops_and_duplicates();
    logic [SEQ_W-1:0] base;
    base = last_delivered_seq;
    send_packet(base + 8'd1, 1'b0, 10'd100, 16'h1111);
    send_packet(base, 1'b1, 10'd100, 16'h2222);
    send_packet(base + 8'd32, 1'b1, 10'd100, 16'h3333);
    send_packet(base + 8'd200, 1'b1, 10'd100, 16'h4444);
    send_packet(base + 8'd31, 1'b1, 10'd100, 16'h5555);
    send_packet(base + 8'd2, 1'b1, 10'd200, 16'h6666);
    send_packet(base + 8'd2, 1'b1, 10'd300, 16'h7777);
    send_packet(base + 8'd1, 1'b1, 10'd400, 16'h8888);
  endtask

  // Fill every slot; with the head last, one packet releases the whole window
  task automatic test_window_fill(input logic head_last);
    int               order [WINDOW];
    int               j;
    int               tmp;
    logic [SEQ_W-1:0] base;
    base = last_delivered_seq + 8'd1;
    for (int i = 0; i < WINDOW; i++) order[i] = WINDOW - 1 - i;
    if (!head_last) begin
      for (int i = WINDOW - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    for (int i = 0; i < WINDOW; i++)
      send_packet(base + SEQ_W'(order[i]), 1'b1, LEN_W'($urandom_range(1, 512)),
                  HANDLE_W'($urandom_range(65535)));
  endtask

  // Short packet buffered ahead of a gap, then the gap closes and done rises
  task automatic test_end_of_transfer();
    logic [SEQ_W-1:0] base;
    base = last_delivered_seq + 8'd1;
    send_packet(base + 8'd1, 1'b1, 10'd0, 16'h9999);
    send_packet(base, 1'b1, 10'd5, 16'hAAAA);
    // keep processing after done
    send_packet(base + 8'd2, 1'b1, 10'd512, 16'hBBBB);
    send_packet(base + 8'd4, 1'b1, 10'd512, 16'hCCCC);
    send_packet(base + 8'd3, 1'b1, 10'd512, 16'hDDDD);
  endtask

  task automatic test_random_traffic();
    write_threshold(10'd512);
    run_random_phase(38, 1'b1);
    write_threshold(10'd1);
    run_random_phase(38, 1'b0);
    write_threshold(LEN_W'($urandom_range(2, 510)));
    steady_sender = 1'b1;
    run_random_phase(38, 1'b0);
    steady_sender = 1'b0;
    test_window_fill(1'b0);
    write_threshold(10'd511);
    run_random_phase(38, 1'b0);
    write_threshold(10'd256);
    run_random_phase(38, 1'b0);
  endtask

  initial begin
    clear_window();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_threshold();
    test_reorder();
    test_drops_and_duplicates();
    test_window_fill(1'b1);
    test_end_of_transfer();
    test_random_traffic();
    drain_results();
    repeat (LATENCY) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
